[rtl/mtf_pkg.sv]
// ----------------------------------------------------------------------------
// mtf_pkg: shared types and constants for the move-to-front recency list
// Holds the list capacity, the transfer payload types, the opcodes and the
// controller states.
// ----------------------------------------------------------------------------
package mtf_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W  = 32;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	typedef struct packed {
		logic                   opcode;
		logic signed [ID_W-1:0] item_id;
	} in_item_t;

	typedef struct packed {
		logic signed [ID_W-1:0] out_id;
		logic                   is_last;
		logic                   list_empty;
		logic                   overflowed;
	} out_item_t;

	// Control broadcast to every cell of the row
	typedef struct packed {
		logic                   access;
		logic                   advance;
		logic signed [ID_W-1:0] key;
	} cell_ctrl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

[rtl/mtf_cell.sv]
// ----------------------------------------------------------------------------
// mtf_cell: one slot of the recency list
// Holds one identifier; compares it with the key, passes the hit-seen flag
// down the row and takes its neighbour's identifier on a shift.
// ----------------------------------------------------------------------------
module mtf_cell (
	input  logic                           clk,
	input  mtf_pkg::cell_ctrl_t            ctrl,
	input  logic                           occupied,
	input  logic signed [mtf_pkg::ID_W-1:0] prev_id,
	input  logic signed [mtf_pkg::ID_W-1:0] next_id,
	input  logic                           seen_in,
	output logic                           seen_out,
	output logic signed [mtf_pkg::ID_W-1:0] id
);

	logic signed [mtf_pkg::ID_W-1:0] id_q;
	logic                            match;

	assign match    = occupied && (id_q == ctrl.key);
	assign seen_out = seen_in || match;
	assign id       = id_q;

	// Shift back behind the hit (or along the whole row on a miss); advance on dump
	always_ff @(posedge clk) begin
		if (ctrl.access && !seen_in) begin
			id_q <= prev_id;
		end else if (ctrl.advance) begin
			id_q <= next_id;
		end
	end

endmodule

[rtl/move_to_front_recency_list.sv]
// ----------------------------------------------------------------------------
// move_to_front_recency_list: most-recently-used list of distinct identifiers
// Row of compare-and-shift cells with a small dump controller.
// ----------------------------------------------------------------------------
// An access transfer (opcode 0) is taken in idle and a new one may follow in
// the next cycle: every cell compares its identifier with the key at once, a
// hit-seen flag ripples down the row, and the cells in front of the hit (all
// of them on a miss) move back one place while the key lands in the head
// cell. A new identifier arriving at a full list drops the tail entry and
// sets a sticky overflow flag. An end-of-group transfer (opcode 1) starts a
// dump: the row advances toward the head one cell per cycle while the result
// side can take a result, giving one result per stored entry (one result
// flagged empty when the list is empty); no input is taken until the last
// result is loaded. After a dump the list is empty and the overflow flag is
// clear. The clock path is the identifier compare plus the hit-seen ripple
// along all DEPTH cells.
// ----------------------------------------------------------------------------
module move_to_front_recency_list (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  mtf_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output mtf_pkg::out_item_t result
);

	mtf_pkg::state_t   state_q, state_d;
	logic [mtf_pkg::CNT_W-1:0] count_q;
	logic              ovf_q;
	logic              result_valid_q;
	mtf_pkg::out_item_t result_q;

	mtf_pkg::cell_ctrl_t ctrl;
	logic              accept;
	logic              access;
	logic              hit;
	logic              full;
	logic              out_free;
	logic              advance;
	logic              last;

	logic [mtf_pkg::DEPTH-1:0] occupied;
	logic [mtf_pkg::DEPTH:0]   seen;
	logic signed [mtf_pkg::ID_W-1:0] ids [mtf_pkg::DEPTH];

	assign accept   = item_valid && item_ready;
	assign access   = accept && (item.opcode == mtf_pkg::OP_ACCESS);
	assign hit      = seen[mtf_pkg::DEPTH];
	assign full     = (count_q == mtf_pkg::CNT_W'(mtf_pkg::DEPTH));
	assign out_free = !result_valid_q || result_ready;
	assign last     = (count_q <= mtf_pkg::CNT_W'(1));

	assign ctrl.access  = access;
	assign ctrl.advance = advance;
	assign ctrl.key     = item.item_id;

	// Cells below the count hold live entries
	always_comb begin
		for (int k = 0; k < mtf_pkg::DEPTH; k++) begin
			occupied[k] = (count_q > mtf_pkg::CNT_W'(k));
		end
	end

	assign seen[0] = 1'b0;

	for (genvar g = 0; g < mtf_pkg::DEPTH; g++) begin : g_cell
		logic signed [mtf_pkg::ID_W-1:0] prev_id;
		logic signed [mtf_pkg::ID_W-1:0] next_id;

		// Head cell takes the key; tail cell refills with zero on dump
		if (g == 0) begin : g_head
			assign prev_id = item.item_id;
		end else begin : g_body
			assign prev_id = ids[g-1];
		end
		if (g == mtf_pkg::DEPTH - 1) begin : g_tail
			assign next_id = '0;
		end else begin : g_mid
			assign next_id = ids[g+1];
		end

		mtf_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occupied[g]),
			.prev_id  (prev_id),
			.next_id  (next_id),
			.seen_in  (seen[g]),
			.seen_out (seen[g+1]),
			.id       (ids[g])
		);
	end

	// Controller: accept in idle, walk the row during a dump
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		advance    = 1'b0;
		unique case (state_q)
			mtf_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (accept && item.opcode == mtf_pkg::OP_DUMP) begin
					state_d = mtf_pkg::ST_DUMP;
				end
			end
			mtf_pkg::ST_DUMP: begin
				advance = out_free;
				if (out_free && last) begin
					state_d = mtf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mtf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Count and sticky overflow: grow on a miss, drop the tail when full, drain on dump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (access && !hit) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + mtf_pkg::CNT_W'(1);
			end
		end else if (advance) begin
			if (count_q != '0) begin
				count_q <= count_q - mtf_pkg::CNT_W'(1);
			end
			if (last) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// Output register: hold until taken, load the head cell on each advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.out_id     <= (count_q == '0) ? '0 : ids[0];
			result_q.is_last    <= last;
			result_q.list_empty <= (count_q == '0);
			result_q.overflowed <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// An empty-list result is always the only, hence last, result of its dump
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.list_empty |-> result.is_last)
		else $error("empty result without last mark");

	// A finished dump leaves an empty list and a clear overflow flag
	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtf_pkg::ST_DUMP && state_d == mtf_pkg::ST_IDLE)
		|=> (count_q == '0 && !ovf_q))
		else $error("list not cleared after dump");

	// The count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mtf_pkg::CNT_W'(mtf_pkg::DEPTH))
		else $error("entry count beyond capacity");

	// A miss into a full list sets the overflow flag and keeps the count
	a_overflow_set: assert property (@(posedge clk) disable iff (!arst_n)
		access && !hit && full |=> ovf_q && full)
		else $error("overflow not recorded on tail drop");

	// A hit never changes the count
	a_hit_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		access && hit |=> $stable(count_q))
		else $error("count changed on a hit");

endmodule
